>>> hdl/lsb_pkg.sv
// ----------------------------------------------------------------------------
// lsb_pkg
// Shared types and constants for the link supervisor with backoff: event
// codes, register indexes, link states, reset values and payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lsb_pkg;

  typedef enum logic [2:0] {
    ST_OFFLINE      = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_AUTH         = 3'd2,
    ST_CONNECTED    = 3'd3,
    ST_RECONNECTING = 3'd4,
    ST_FAILED       = 3'd5
  } lsb_state_t;

  localparam logic [3:0] EV_TICK         = 4'd0;
  localparam logic [3:0] EV_CONNECT_REQ  = 4'd1;
  localparam logic [3:0] EV_DISCONNECT   = 4'd2;
  localparam logic [3:0] EV_CONNECT_FAIL = 4'd3;
  localparam logic [3:0] EV_OPENED       = 4'd4;
  localparam logic [3:0] EV_CLOSED       = 4'd5;
  localparam logic [3:0] EV_PING         = 4'd6;
  localparam logic [3:0] EV_ACTIVITY     = 4'd7;
  localparam logic [3:0] EV_WELCOME      = 4'd8;
  localparam logic [3:0] EV_DISABLE      = 4'd9;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AUTH_TIMEOUT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PING_INTERVAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INITIAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_CAP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAILED_HOLD      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_CONFIGURED  = 3'd7;

  localparam logic [31:0] RST_AUTH_TIMEOUT     = 32'd10000;
  localparam logic [31:0] RST_PING_INTERVAL    = 32'd30000;
  localparam logic [31:0] RST_ACTIVITY_TIMEOUT = 32'd90000;
  localparam logic [31:0] RST_RETRY_INITIAL    = 32'd1000;
  localparam logic [31:0] RST_RETRY_CAP        = 32'd60000;
  localparam logic [7:0]  RST_ATTEMPT_LIMIT    = 8'd10;
  localparam logic [31:0] RST_FAILED_HOLD      = 32'd300000;

  localparam logic [7:0] CNT_MAX = 8'hFF;
  localparam logic [7:0] SHIFT_SAT = 8'd32;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] now;
  } lsb_in_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic [7:0] attempts;
    logic       disabled;
    logic       start_connect;
    logic       close_link;
    logic       send_ping;
    logic       send_pong;
    logic       send_hello;
    logic       send_ack;
  } lsb_out_t;

endpackage

`default_nettype wire

>>> hdl/link_supervisor_backoff_core.sv
// ----------------------------------------------------------------------------
// link_supervisor_backoff_core
// Six-state link supervisor with timeouts, pings and capped exponential
// retry backoff. One result per event, registered at the output.
// ----------------------------------------------------------------------------
// Path: the input transfer is captured in the input register, then the
//   state update is written together with the result register, so the
//   result is registered at the output.
// Throughput: one event per cycle when not stalled; the state update is a
//   single pass of compares, one 64-bit capped shift and a subtract per timer.
// Reset: synchronous, active low; registers, timestamps and state return
//   to their power-on values, both stages empty.
`default_nettype none

module link_supervisor_backoff_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lsb_pkg::lsb_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lsb_pkg::lsb_out_t                     out_data,
  input  wire logic                             cfg_we,
  input  wire logic [lsb_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [lsb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [31:0] auth_timeout_r, ping_interval_r, activity_timeout_r;
  logic [31:0] retry_initial_r, retry_cap_r, failed_hold_r;
  logic [7:0]  attempt_limit_r;
  logic        peer_cfg_r;

  lsb_pkg::lsb_state_t state_r, state_nxt;
  logic [31:0] last_act_r, last_act_nxt;
  logic [31:0] last_ping_r, last_ping_nxt;
  logic [31:0] last_retry_r, last_retry_nxt;
  logic [31:0] auth_start_r, auth_start_nxt;
  logic [31:0] failed_start_r, failed_start_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        dis_r, dis_nxt;

  logic              in_vld_r;
  lsb_pkg::lsb_in_t  in_r;
  logic              out_vld_r;
  lsb_pkg::lsb_out_t out_r, out_nxt;

  logic adv;
  logic [63:0] shifted;
  logic [31:0] delay;
  logic [7:0]  cnt_inc;
  logic        go;
  lsb_pkg::lsb_state_t tgt;

  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign shifted = {32'd0, retry_initial_r} << cnt_r[4:0];
  assign delay   = (retry_initial_r == 32'd0) ? 32'd0 :
                   (cnt_r >= lsb_pkg::SHIFT_SAT || shifted[63:32] != 32'd0 ||
                    shifted[31:0] > retry_cap_r) ? retry_cap_r : shifted[31:0];
  assign cnt_inc = (cnt_r == lsb_pkg::CNT_MAX) ? cnt_r : cnt_r + 8'd1;

  always_comb begin
    state_nxt        = state_r;
    last_act_nxt     = last_act_r;
    last_ping_nxt    = last_ping_r;
    last_retry_nxt   = last_retry_r;
    auth_start_nxt   = auth_start_r;
    failed_start_nxt = failed_start_r;
    cnt_nxt          = cnt_r;
    dis_nxt          = dis_r;
    go               = 1'b0;
    tgt              = state_r;
    out_nxt          = '0;

    case (in_r.func)
      lsb_pkg::EV_TICK: begin
        case (state_r)
          lsb_pkg::ST_AUTH: begin
            if (32'(in_r.now - auth_start_r) > auth_timeout_r) begin
              out_nxt.close_link = 1'b1;
              go  = 1'b1;
              tgt = lsb_pkg::ST_RECONNECTING;
            end
          end
          lsb_pkg::ST_CONNECTED: begin
            if (32'(in_r.now - last_ping_r) > ping_interval_r) begin
              out_nxt.send_ping = 1'b1;
              last_ping_nxt     = in_r.now;
            end
            if (32'(in_r.now - last_act_r) > activity_timeout_r) begin
              out_nxt.close_link = 1'b1;
              go  = 1'b1;
              tgt = lsb_pkg::ST_RECONNECTING;
            end
          end
          lsb_pkg::ST_RECONNECTING: begin
            if (32'(in_r.now - last_retry_r) >= delay) begin
              cnt_nxt        = cnt_inc;
              last_retry_nxt = in_r.now;
              if (cnt_inc > attempt_limit_r) begin
                go  = 1'b1;
                tgt = lsb_pkg::ST_FAILED;
              end else begin
                out_nxt.start_connect = 1'b1;
              end
            end
          end
          lsb_pkg::ST_FAILED: begin
            if (32'(in_r.now - failed_start_r) > failed_hold_r) begin
              cnt_nxt = '0;
              go      = 1'b1;
              tgt     = lsb_pkg::ST_OFFLINE;
            end
          end
          default: begin
          end
        endcase
      end
      lsb_pkg::EV_CONNECT_REQ: begin
        if ((state_r == lsb_pkg::ST_OFFLINE || state_r == lsb_pkg::ST_RECONNECTING) &&
            peer_cfg_r) begin
          go  = 1'b1;
          tgt = lsb_pkg::ST_CONNECTING;
          out_nxt.start_connect = 1'b1;
        end
      end
      lsb_pkg::EV_DISCONNECT: begin
        out_nxt.close_link = 1'b1;
        go  = 1'b1;
        tgt = lsb_pkg::ST_OFFLINE;
      end
      lsb_pkg::EV_CONNECT_FAIL: begin
        if (state_r == lsb_pkg::ST_CONNECTING) begin
          go  = 1'b1;
          tgt = lsb_pkg::ST_RECONNECTING;
        end
      end
      lsb_pkg::EV_OPENED: begin
        cnt_nxt            = '0;
        last_act_nxt       = in_r.now;
        auth_start_nxt     = in_r.now;
        out_nxt.send_hello = 1'b1;
        go  = 1'b1;
        tgt = lsb_pkg::ST_AUTH;
      end
      lsb_pkg::EV_CLOSED: begin
        if (state_r == lsb_pkg::ST_CONNECTED || state_r == lsb_pkg::ST_AUTH) begin
          go  = 1'b1;
          tgt = lsb_pkg::ST_RECONNECTING;
        end
      end
      lsb_pkg::EV_PING: begin
        out_nxt.send_pong = 1'b1;
        last_act_nxt      = in_r.now;
      end
      lsb_pkg::EV_ACTIVITY: begin
        last_act_nxt = in_r.now;
      end
      lsb_pkg::EV_WELCOME: begin
        last_act_nxt = in_r.now;
        if (state_r == lsb_pkg::ST_AUTH) begin
          go            = 1'b1;
          tgt           = lsb_pkg::ST_CONNECTED;
          last_ping_nxt = in_r.now;
        end
      end
      lsb_pkg::EV_DISABLE: begin
        last_act_nxt       = in_r.now;
        dis_nxt            = 1'b1;
        out_nxt.send_ack   = 1'b1;
        out_nxt.close_link = 1'b1;
        go  = 1'b1;
        tgt = lsb_pkg::ST_OFFLINE;
      end
      default: begin
      end
    endcase

    // apply the state change; entry actions only on a real change
    if (go && tgt != state_r) begin
      state_nxt = tgt;
      if (tgt == lsb_pkg::ST_FAILED) begin
        failed_start_nxt = in_r.now;
      end else if (tgt == lsb_pkg::ST_RECONNECTING) begin
        last_retry_nxt = '0;
      end
    end

    out_nxt.link_state = state_nxt;
    out_nxt.attempts   = cnt_nxt;
    out_nxt.disabled   = dis_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auth_timeout_r     <= lsb_pkg::RST_AUTH_TIMEOUT;
      ping_interval_r    <= lsb_pkg::RST_PING_INTERVAL;
      activity_timeout_r <= lsb_pkg::RST_ACTIVITY_TIMEOUT;
      retry_initial_r    <= lsb_pkg::RST_RETRY_INITIAL;
      retry_cap_r        <= lsb_pkg::RST_RETRY_CAP;
      attempt_limit_r    <= lsb_pkg::RST_ATTEMPT_LIMIT;
      failed_hold_r      <= lsb_pkg::RST_FAILED_HOLD;
      peer_cfg_r         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lsb_pkg::REG_AUTH_TIMEOUT:     auth_timeout_r     <= cfg_wdata;
        lsb_pkg::REG_PING_INTERVAL:    ping_interval_r    <= cfg_wdata;
        lsb_pkg::REG_ACTIVITY_TIMEOUT: activity_timeout_r <= cfg_wdata;
        lsb_pkg::REG_RETRY_INITIAL:    retry_initial_r    <= cfg_wdata;
        lsb_pkg::REG_RETRY_CAP:        retry_cap_r        <= cfg_wdata;
        lsb_pkg::REG_ATTEMPT_LIMIT:    attempt_limit_r    <= cfg_wdata[7:0];
        lsb_pkg::REG_FAILED_HOLD:      failed_hold_r      <= cfg_wdata;
        lsb_pkg::REG_PEER_CONFIGURED:  peer_cfg_r         <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lsb_pkg::ST_OFFLINE;
      last_act_r     <= '0;
      last_ping_r    <= '0;
      last_retry_r   <= '0;
      auth_start_r   <= '0;
      failed_start_r <= '0;
      cnt_r          <= '0;
      dis_r          <= 1'b0;
    end else if (adv) begin
      state_r        <= state_nxt;
      last_act_r     <= last_act_nxt;
      last_ping_r    <= last_ping_nxt;
      last_retry_r   <= last_retry_nxt;
      auth_start_r   <= auth_start_nxt;
      failed_start_r <= failed_start_nxt;
      cnt_r          <= cnt_nxt;
      dis_r          <= dis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed event did not produce a result");

  a_connect_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.start_connect |->
      (out_r.link_state == lsb_pkg::ST_CONNECTING ||
       out_r.link_state == lsb_pkg::ST_RECONNECTING))
    else $error("connect strobe in unexpected state");

  a_hello_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.send_hello |->
      (out_r.link_state == lsb_pkg::ST_AUTH && out_r.attempts == 8'd0))
    else $error("hello strobe without fresh authentication");

  a_disable_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dis_r |=> dis_r)
    else $error("disable flag cleared");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for link_supervisor_backoff_core. A scoreboard model of
// the supervisor predicts state, retry count and command strobes for every
// event transfer. Stimulus runs through directed boundary cases, random
// connect sessions under several register settings, and a retry counter
// saturation run, with random idle and stall on both channels.
// ----------------------------------------------------------------------------

module tb_top;

  typedef enum int {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  localparam int unsigned STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  lsb_pkg::lsb_in_t                      in_data = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  lsb_pkg::lsb_out_t                     out_data;
  logic                                  cfg_we = 1'b0;
  logic [lsb_pkg::CFG_IDX_W-1:0]         cfg_addr = '0;
  logic [lsb_pkg::CFG_DATA_W-1:0]        cfg_wdata = '0;

  link_supervisor_backoff_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoreboard copy of the registers
  logic [31:0] c_auth_to, c_ping_iv, c_act_to, c_retry_init, c_retry_cap, c_failed_hold;
  logic [7:0]  c_att_limit;
  logic        c_peer;

  // scoreboard copy of the supervisor state
  lsb_pkg::lsb_state_t lk_state;
  logic [31:0] t_activity, t_ping, t_retry, t_auth, t_failed;
  logic [7:0]  n_retry;
  logic        dis_flag;

  lsb_pkg::lsb_in_t  ev_backlog [$];
  lsb_pkg::lsb_out_t due_results [$];
  lsb_pkg::lsb_out_t due;
  int unsigned n_queued = 0;
  int unsigned n_fail = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] t_ms = '0;
  logic [31:0] span_ms = 32'd100;

  function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] mark);
    return now - mark;
  endfunction

  function automatic void move_to(input lsb_pkg::lsb_state_t nxt, input logic [31:0] now);
    if (lk_state != nxt) begin
      lk_state = nxt;
      if (nxt == lsb_pkg::ST_FAILED) t_failed = now;
      else if (nxt == lsb_pkg::ST_RECONNECTING) t_retry = '0;
    end
  endfunction

  function automatic lsb_pkg::lsb_out_t link_next(input lsb_pkg::lsb_in_t ev);
    lsb_pkg::lsb_out_t r;
    logic [31:0] t;
    logic [31:0] wait_ms;
    logic [63:0] wide;
    r = '0;
    t = ev.now;
    case (ev.func)
      lsb_pkg::EV_TICK: begin
        case (lk_state)
          lsb_pkg::ST_AUTH: begin
            if (since(t, t_auth) > c_auth_to) begin
              r.close_link = 1'b1;
              move_to(lsb_pkg::ST_RECONNECTING, t);
            end
          end
          lsb_pkg::ST_CONNECTED: begin
            if (since(t, t_ping) > c_ping_iv) begin
              r.send_ping = 1'b1;
              t_ping = t;
            end
            if (since(t, t_activity) > c_act_to) begin
              r.close_link = 1'b1;
              move_to(lsb_pkg::ST_RECONNECTING, t);
            end
          end
          lsb_pkg::ST_RECONNECTING: begin
            // capped exponential delay, shift saturates at the cap
            if (c_retry_init == '0) begin
              wait_ms = '0;
            end else if (n_retry >= lsb_pkg::SHIFT_SAT) begin
              wait_ms = c_retry_cap;
            end else begin
              wide = {32'd0, c_retry_init} << n_retry;
              wait_ms = (wide > {32'd0, c_retry_cap}) ? c_retry_cap : wide[31:0];
            end
            if (since(t, t_retry) >= wait_ms) begin
              if (n_retry != lsb_pkg::CNT_MAX) n_retry = n_retry + 8'd1;
              t_retry = t;
              if (n_retry > c_att_limit) move_to(lsb_pkg::ST_FAILED, t);
              else r.start_connect = 1'b1;
            end
          end
          lsb_pkg::ST_FAILED: begin
            if (since(t, t_failed) > c_failed_hold) begin
              n_retry = '0;
              move_to(lsb_pkg::ST_OFFLINE, t);
            end
          end
          default: ;
        endcase
      end
      lsb_pkg::EV_CONNECT_REQ: begin
        if ((lk_state == lsb_pkg::ST_OFFLINE || lk_state == lsb_pkg::ST_RECONNECTING) &&
            c_peer) begin
          move_to(lsb_pkg::ST_CONNECTING, t);
          r.start_connect = 1'b1;
        end
      end
      lsb_pkg::EV_DISCONNECT: begin
        r.close_link = 1'b1;
        move_to(lsb_pkg::ST_OFFLINE, t);
      end
      lsb_pkg::EV_CONNECT_FAIL: begin
        if (lk_state == lsb_pkg::ST_CONNECTING) move_to(lsb_pkg::ST_RECONNECTING, t);
      end
      lsb_pkg::EV_OPENED: begin
        n_retry = '0;
        t_activity = t;
        move_to(lsb_pkg::ST_AUTH, t);
        t_auth = t;
        r.send_hello = 1'b1;
      end
      lsb_pkg::EV_CLOSED: begin
        if (lk_state == lsb_pkg::ST_CONNECTED || lk_state == lsb_pkg::ST_AUTH)
          move_to(lsb_pkg::ST_RECONNECTING, t);
      end
      lsb_pkg::EV_PING: begin
        r.send_pong = 1'b1;
        t_activity = t;
      end
      lsb_pkg::EV_ACTIVITY: begin
        t_activity = t;
      end
      lsb_pkg::EV_WELCOME: begin
        t_activity = t;
        if (lk_state == lsb_pkg::ST_AUTH) begin
          move_to(lsb_pkg::ST_CONNECTED, t);
          t_ping = t;
        end
      end
      lsb_pkg::EV_DISABLE: begin
        t_activity = t;
        dis_flag = 1'b1;
        r.send_ack = 1'b1;
        r.close_link = 1'b1;
        move_to(lsb_pkg::ST_OFFLINE, t);
      end
      default: ;
    endcase
    r.link_state = lk_state;
    r.attempts = n_retry;
    r.disabled = dis_flag;
    return r;
  endfunction

  function automatic void store_reg(input logic [lsb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] val);
    case (idx)
      lsb_pkg::REG_AUTH_TIMEOUT:     c_auth_to = val;
      lsb_pkg::REG_PING_INTERVAL:    c_ping_iv = val;
      lsb_pkg::REG_ACTIVITY_TIMEOUT: c_act_to = val;
      lsb_pkg::REG_RETRY_INITIAL:    c_retry_init = val;
      lsb_pkg::REG_RETRY_CAP:        c_retry_cap = val;
      lsb_pkg::REG_ATTEMPT_LIMIT:    c_att_limit = val[7:0];
      lsb_pkg::REG_FAILED_HOLD:      c_failed_hold = val;
      lsb_pkg::REG_PEER_CONFIGURED:  c_peer = val[0];
      default: ;
    endcase
  endfunction

  function automatic void send_at(input logic [3:0] func, input logic [31:0] now);
    lsb_pkg::lsb_in_t ev;
    ev.func = func;
    ev.now = now;
    ev_backlog.push_back(ev);
    n_queued++;
  endfunction

  task automatic send(input logic [3:0] func);
    int unsigned r;
    logic [31:0] gap;
    r = $urandom_range(0, 99);
    if (r < 10) gap = '0;
    else if (r < 15) gap = 32'd1;
    else if (r < 22) gap = span_ms;
    else if (r < 96) gap = $urandom_range(0, span_ms);
    else gap = $urandom;
    t_ms = t_ms + gap;
    send_at(func, t_ms);
  endtask

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FREE:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      PACE_SEND_IDLE:  begin tx_idle_pct = 77; rx_stall_pct = 0;  end
      PACE_RECV_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
      default:         begin tx_idle_pct = 32; rx_stall_pct = 32; end
    endcase
  endtask

  // hold new transfers until every predicted result has come back
  task automatic drain();
    do @(negedge clk); while (ev_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] auth, input logic [31:0] ping,
                              input logic [31:0] act, input logic [31:0] rinit,
                              input logic [31:0] rcap, input logic [7:0] limit,
                              input logic [31:0] hold, input logic peer);
    logic [31:0] val [8];
    int i;
    val[lsb_pkg::REG_AUTH_TIMEOUT]     = auth;
    val[lsb_pkg::REG_PING_INTERVAL]    = ping;
    val[lsb_pkg::REG_ACTIVITY_TIMEOUT] = act;
    val[lsb_pkg::REG_RETRY_INITIAL]    = rinit;
    val[lsb_pkg::REG_RETRY_CAP]        = rcap;
    val[lsb_pkg::REG_ATTEMPT_LIMIT]    = {24'd0, limit};
    val[lsb_pkg::REG_FAILED_HOLD]      = hold;
    val[lsb_pkg::REG_PEER_CONFIGURED]  = {31'd0, peer};
    for (i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= i[lsb_pkg::CFG_IDX_W-1:0];
      cfg_wdata <= val[i];
      store_reg(i[lsb_pkg::CFG_IDX_W-1:0], val[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_session();
    int unsigned path;
    int unsigned k;
    path = $urandom_range(0, 99);
    send(lsb_pkg::EV_CONNECT_REQ);
    if (path < 35) begin
      send(lsb_pkg::EV_CONNECT_FAIL);
      repeat ($urandom_range(1, 8)) send(lsb_pkg::EV_TICK);
    end else begin
      send(lsb_pkg::EV_OPENED);
      if (path < 50) begin
        repeat ($urandom_range(1, 4)) send(lsb_pkg::EV_TICK);
      end else begin
        send(lsb_pkg::EV_WELCOME);
        repeat ($urandom_range(2, 10)) begin
          k = $urandom_range(0, 9);
          send(k < 6 ? lsb_pkg::EV_TICK :
               (k < 8 ? lsb_pkg::EV_ACTIVITY : lsb_pkg::EV_PING));
        end
        case ($urandom_range(0, 3))
          0: send(lsb_pkg::EV_CLOSED);
          1: send(lsb_pkg::EV_DISCONNECT);
          2: send(lsb_pkg::EV_DISABLE);
          default: ;
        endcase
      end
    end
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned goal;
    goal = n_queued + n_items;
    while (n_queued < goal) begin
      if ($urandom_range(0, 99) < 20) send(4'($urandom_range(0, 15)));
      else queue_session();
    end
  endtask

  task automatic run_phase(input logic [31:0] auth, input logic [31:0] ping,
                           input logic [31:0] act, input logic [31:0] rinit,
                           input logic [31:0] rcap, input logic [7:0] limit,
                           input logic [31:0] hold, input logic peer,
                           input logic [31:0] span, input logic [31:0] t0,
                           input int unsigned n_items, input pace_t pace_a,
                           input pace_t pace_b);
    program_regs(auth, ping, act, rinit, rcap, limit, hold, peer);
    span_ms = span;
    t_ms = t0;
    set_pace(pace_a);
    random_traffic(n_items / 2);
    drain();
    set_pace(pace_b);
    random_traffic(n_items - n_items / 2);
    drain();
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(link_next(in_data));
      end
      if (!in_valid || in_ready) begin
        if (ev_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= ev_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      n_fail++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        n_fail++;
      end else begin
        due = due_results.pop_front();
        cmp_field("link_state", 32'(due.link_state), 32'(out_data.link_state));
        cmp_field("attempts", 32'(due.attempts), 32'(out_data.attempts));
        cmp_field("disabled", 32'(due.disabled), 32'(out_data.disabled));
        cmp_field("start_connect", 32'(due.start_connect), 32'(out_data.start_connect));
        cmp_field("close_link", 32'(due.close_link), 32'(out_data.close_link));
        cmp_field("send_ping", 32'(due.send_ping), 32'(out_data.send_ping));
        cmp_field("send_pong", 32'(due.send_pong), 32'(out_data.send_pong));
        cmp_field("send_hello", 32'(due.send_hello), 32'(out_data.send_hello));
        cmp_field("send_ack", 32'(due.send_ack), 32'(out_data.send_ack));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("link_supervisor_backoff_core regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    c_auth_to = lsb_pkg::RST_AUTH_TIMEOUT;
    c_ping_iv = lsb_pkg::RST_PING_INTERVAL;
    c_act_to = lsb_pkg::RST_ACTIVITY_TIMEOUT;
    c_retry_init = lsb_pkg::RST_RETRY_INITIAL;
    c_retry_cap = lsb_pkg::RST_RETRY_CAP;
    c_att_limit = lsb_pkg::RST_ATTEMPT_LIMIT;
    c_failed_hold = lsb_pkg::RST_FAILED_HOLD;
    c_peer = 1'b0;
    lk_state = lsb_pkg::ST_OFFLINE;
    t_activity = '0;
    t_ping = '0;
    t_retry = '0;
    t_auth = '0;
    t_failed = '0;
    n_retry = '0;
    dis_flag = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // power-on settings: connect request without a peer, unused codes
    set_pace(PACE_FREE);
    send_at(lsb_pkg::EV_CONNECT_REQ, 32'd0);
    send_at(4'd15, 32'hFFFF_FFFF);
    send_at(4'd10, 32'd7);
    drain();
    program_regs(lsb_pkg::RST_AUTH_TIMEOUT, lsb_pkg::RST_PING_INTERVAL,
                 lsb_pkg::RST_ACTIVITY_TIMEOUT, lsb_pkg::RST_RETRY_INITIAL,
                 lsb_pkg::RST_RETRY_CAP, lsb_pkg::RST_ATTEMPT_LIMIT,
                 lsb_pkg::RST_FAILED_HOLD, 1'b1);

    // backoff edges, auth and activity timeouts, ping interval edges
    send_at(lsb_pkg::EV_CONNECT_REQ, 32'd100);
    send_at(lsb_pkg::EV_CONNECT_FAIL, 32'd200);
    send_at(lsb_pkg::EV_TICK, 32'd500);
    send_at(lsb_pkg::EV_TICK, 32'd1000);
    send_at(lsb_pkg::EV_TICK, 32'd2999);
    send_at(lsb_pkg::EV_TICK, 32'd3000);
    send_at(lsb_pkg::EV_CONNECT_REQ, 32'd3100);
    send_at(lsb_pkg::EV_OPENED, 32'd3200);
    send_at(lsb_pkg::EV_TICK, 32'd13200);
    send_at(lsb_pkg::EV_PING, 32'd13201);
    send_at(lsb_pkg::EV_WELCOME, 32'd13300);
    send_at(lsb_pkg::EV_TICK, 32'd43300);
    send_at(lsb_pkg::EV_TICK, 32'd43301);
    send_at(lsb_pkg::EV_ACTIVITY, 32'd50000);
    send_at(lsb_pkg::EV_TICK, 32'd140001);
    send_at(lsb_pkg::EV_OPENED, 32'd140100);
    send_at(lsb_pkg::EV_TICK, 32'd150101);
    send_at(lsb_pkg::EV_CLOSED, 32'd150200);
    send_at(lsb_pkg::EV_DISABLE, 32'hFFFF_FFF0);
    send_at(lsb_pkg::EV_CONNECT_REQ, 32'hFFFF_FFF8);
    send_at(lsb_pkg::EV_DISCONNECT, 32'd0);
    send_at(lsb_pkg::EV_TICK, 32'd5);
    drain();

    run_phase(32'd20, 32'd10, 32'd50, 32'd4, 32'd64, 8'd3, 32'd100, 1'b1,
              32'd80, 32'd0, 120, PACE_FREE, PACE_SEND_IDLE);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0, 1'b1,
              32'd4, 32'hFFFF_FFF0, 100, PACE_RECV_STALL, PACE_BOTH);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              8'd254, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd0, 80, PACE_SEND_IDLE,
              PACE_FREE);
    run_phase(32'd1000, 32'd300, 32'd2000, 32'h8000_0000, 32'hFFFF_FFFF, 8'd2, 32'd5000,
              1'b0, 32'd1500, 32'hFFFF_F000, 60, PACE_BOTH, PACE_RECV_STALL);
    run_phase(32'd100, 32'd40, 32'd300, 32'd3, 32'd200, 8'd4, 32'd1000, 1'b1,
              32'd400, 32'h7FFF_FF00, 100, PACE_FREE, PACE_BOTH);

    // retry counter: climb past the shift limit, then saturate
    program_regs(32'd100, 32'd40, 32'd300, 32'd0, 32'd200, 8'd254, 32'hFFFF_FFFF, 1'b1);
    set_pace(PACE_BOTH);
    span_ms = 32'd10;
    send(lsb_pkg::EV_DISCONNECT);
    send(lsb_pkg::EV_CONNECT_REQ);
    send(lsb_pkg::EV_CONNECT_FAIL);
    repeat (40) send(lsb_pkg::EV_TICK);
    drain();
    program_regs(32'd100, 32'd40, 32'd300, 32'd5, 32'd700, 8'd254, 32'hFFFF_FFFF, 1'b1);
    set_pace(PACE_RECV_STALL);
    span_ms = 32'd1400;
    repeat (30) send(lsb_pkg::EV_TICK);
    drain();
    program_regs(32'd100, 32'd40, 32'd300, 32'd0, 32'd700, 8'd254, 32'hFFFF_FFFF, 1'b1);
    set_pace(PACE_FREE);
    span_ms = 32'd10;
    repeat (225) send(lsb_pkg::EV_TICK);
    send(lsb_pkg::EV_DISCONNECT);
    send(lsb_pkg::EV_CONNECT_REQ);
    send(lsb_pkg::EV_CONNECT_FAIL);
    send(lsb_pkg::EV_TICK);
    send(lsb_pkg::EV_TICK);
    send(lsb_pkg::EV_PING);
    drain();

    repeat (8) @(negedge clk);
    if (n_fail == 0) begin
      $display("link_supervisor_backoff_core regression: pass");
    end else begin
      $display("link_supervisor_backoff_core regression: fail");
    end
    $finish;
  end

endmodule

>>> link_supervisor_backoff_core.f
hdl/lsb_pkg.sv
hdl/link_supervisor_backoff_core.sv
tb/sv/tb_top.sv
